@@ rtl/wmf_pkg.sv @@
// Package for the watermark FIFO flood monitor: word types, codes and constants.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package wmf_pkg;

  // Field widths
  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned TOL_W    = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Percent scale of the thresholds
  localparam int unsigned PCT_SCALE = 100;

  // Request codes
  localparam logic [1:0] REQ_APPEND   = 2'd0;
  localparam logic [1:0] REQ_DISPATCH = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_APPENDED   = 3'd0;
  localparam logic [2:0] ST_DROPPED    = 3'd1;
  localparam logic [2:0] ST_DISPATCHED = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_TICK       = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_PCT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_TOL  = 2'd2;

  // Configuration reset values
  localparam logic [PCT_W-1:0] WARN_PCT_RST   = 7'd90;
  localparam logic [PCT_W-1:0] NORMAL_PCT_RST = 7'd70;
  localparam logic [TOL_W-1:0] FLOOD_TOL_RST  = 10'd15;

  // Fill monitor levels
  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_WARN   = 2'd1,
    LVL_FULL   = 2'd2,
    LVL_FLOOD  = 2'd3
  } level_e;

  // Pending level notices
  typedef struct packed {
    logic normal;
    logic flood;
    logic full;
    logic warn;
  } notice_t;

  // Input word
  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] msg_handle;
    logic [LENGTH_W-1:0] msg_length;
  } req_t;

  // Result word
  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [LENGTH_W-1:0] out_length;
    logic [COUNT_W-1:0]  fill_count;
    logic [1:0]          fill_level;
    logic                notice_warn;
    logic                notice_full;
    logic                notice_flood;
    logic                notice_normal;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EXEC = 2'd1,
    CS_RESP = 2'd2
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch the accepted word
    logic exec;   // ring access and level update
    logic resp;   // result word is on the ports
  } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/wmf_ctrl.sv @@
// Controller of the watermark FIFO flood monitor: accept / execute / respond sequence.
// Depends on wmf_pkg.
`default_nettype none

module wmf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output wmf_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy
);
  import wmf_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      CS_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = CS_RESP;
      end
      CS_RESP: begin
        cmd_o.resp = 1'b1;
        state_d    = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.exec, cmd_o.resp}))
    else $error("controller issued overlapping commands");
  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("accepted word not executed next cycle");
  a_exec_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> cmd_o.resp && busy)
    else $error("execution not followed by a result");
`endif

endmodule

`default_nettype wire

@@ rtl/wmf_dp.sv @@
// Datapath of the watermark FIFO flood monitor: ring memory, pointers, level monitor,
// configuration registers and result registers. Depends on wmf_pkg.
`default_nettype none

module wmf_dp #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire wmf_pkg::ctrl_cmd_t             cmd_i,
  input  wire wmf_pkg::req_t                  req_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wmf_pkg::CFG_W-1:0]      cfg_wdata_i,
  output wmf_pkg::rsp_t                       rsp_o
);
  import wmf_pkg::*;

  localparam int unsigned PW      = $clog2(SLOTS);
  localparam int unsigned CAP     = SLOTS - 1;
  localparam int unsigned MW      = PW + PCT_W;
  localparam int unsigned ENTRY_W = HANDLE_W + LENGTH_W;

  // Configuration registers
  logic [PCT_W-1:0] warn_pct_q, normal_pct_q;
  logic [TOL_W-1:0] flood_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_pct_q   <= WARN_PCT_RST;
      normal_pct_q <= NORMAL_PCT_RST;
      flood_tol_q  <= FLOOD_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WARN_PCT:   warn_pct_q   <= cfg_wdata_i[PCT_W-1:0];
        CFG_NORMAL_PCT: normal_pct_q <= cfg_wdata_i[PCT_W-1:0];
        CFG_FLOOD_TOL:  flood_tol_q  <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Accepted word
  req_t req_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Ring and monitor state
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d, cnt_q, cnt_d;
  level_e           level_q, level_d;
  logic [TOL_W-1:0] sec_q, sec_d;
  notice_t          pend_q, pend_d;

  // Result registers
  logic [2:0]         status_q, status_d;
  notice_t            notes_q, notes_d;
  logic               disp_q, disp_d;
  logic [ENTRY_W-1:0] rdata_q;
  logic               wr_en;

  // Threshold tests on the occupancy before the access
  logic [MW-1:0] occ_scaled, warn_scaled, normal_scaled;
  logic          ring_full, at_warn, at_normal;

  assign occ_scaled    = MW'(cnt_q) * MW'(PCT_SCALE);
  assign warn_scaled   = MW'(warn_pct_q) * MW'(CAP);
  assign normal_scaled = MW'(normal_pct_q) * MW'(CAP);
  assign ring_full     = (cnt_q == PW'(CAP));
  assign at_warn       = (occ_scaled >= warn_scaled);
  assign at_normal     = (occ_scaled <= normal_scaled);

  // Request execution
  always_comb begin
    wr_d     = wr_q;
    rd_d     = rd_q;
    cnt_d    = cnt_q;
    level_d  = level_q;
    sec_d    = sec_q;
    pend_d   = pend_q;
    status_d = ST_TICK;
    notes_d  = '0;
    disp_d   = 1'b0;
    wr_en    = 1'b0;
    if (cmd_i.exec) begin
      case (req_q.req_type)
        REQ_APPEND: begin
          case (level_q)
            LVL_NORMAL: begin
              if (ring_full) begin
                level_d     = LVL_FULL;
                pend_d.full = 1'b1;
                sec_d       = '0;
              end else if (at_warn) begin
                level_d     = LVL_WARN;
                pend_d.warn = 1'b1;
              end
            end
            LVL_WARN: begin
              if (ring_full) begin
                level_d     = LVL_FULL;
                pend_d.full = 1'b1;
                sec_d       = '0;
              end
            end
            LVL_FULL: begin
              if (sec_q >= flood_tol_q) begin
                level_d      = LVL_FLOOD;
                pend_d.flood = 1'b1;
              end
            end
            default: ;
          endcase
          if (ring_full) begin
            status_d = ST_DROPPED;
          end else begin
            wr_en    = 1'b1;
            wr_d     = (wr_q == PW'(CAP)) ? '0 : wr_q + 1'b1;
            cnt_d    = cnt_q + 1'b1;
            status_d = ST_APPENDED;
          end
        end
        REQ_DISPATCH: begin
          if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            if (level_q == LVL_WARN) begin
              if (at_normal) begin
                level_d       = LVL_NORMAL;
                pend_d.normal = 1'b1;
              end
            end else if (level_q == LVL_FULL || level_q == LVL_FLOOD) begin
              if (!at_warn) level_d = LVL_WARN;
              if (at_normal) begin
                level_d       = LVL_NORMAL;
                pend_d.normal = 1'b1;
              end
            end
            notes_d  = pend_d;
            pend_d   = '0;
            rd_d     = (rd_q == PW'(CAP)) ? '0 : rd_q + 1'b1;
            cnt_d    = cnt_q - 1'b1;
            disp_d   = 1'b1;
            status_d = ST_DISPATCHED;
          end
        end
        REQ_TICK: begin
          if (level_q == LVL_FULL && sec_q != '1) sec_d = sec_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      level_q <= LVL_NORMAL;
      sec_q   <= '0;
      pend_q  <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
      sec_q   <= sec_d;
      pend_q  <= pend_d;
    end
  end

  // Result registers, loaded at execution
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      notes_q  <= notes_d;
      disp_q   <= disp_d;
    end
  end

  // Ring memory: at most one write and one registered read per item
  logic [ENTRY_W-1:0] mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= {req_q.msg_handle, req_q.msg_length};
    end
    if (cmd_i.exec) begin
      rdata_q <= mem_q[rd_q];
    end
  end

  // Result word; level and count registers already hold the post-item values
  always_comb begin
    rsp_o               = '0;
    rsp_o.status        = status_q;
    rsp_o.out_handle    = disp_q ? rdata_q[ENTRY_W-1:LENGTH_W] : '0;
    rsp_o.out_length    = disp_q ? rdata_q[LENGTH_W-1:0] : '0;
    rsp_o.fill_count    = COUNT_W'(cnt_q);
    rsp_o.fill_level    = level_q;
    rsp_o.notice_warn   = notes_q.warn;
    rsp_o.notice_full   = notes_q.full;
    rsp_o.notice_flood  = notes_q.flood;
    rsp_o.notice_normal = notes_q.normal;
  end

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PW'(CAP))
    else $error("occupancy above ring capacity");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty ring with diverging pointers");
  a_notice_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && disp_d) |=> (pend_q == '0) && disp_q)
    else $error("pending notices survive a dispatch");
  a_notes_only_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.resp && status_q != ST_DISPATCHED) |-> (notes_q == '0) && !disp_q)
    else $error("notices reported without a dispatch");
`endif

endmodule

`default_nettype wire

@@ rtl/watermark_fifo_flood_monitor.sv @@
// Top level of the watermark FIFO flood monitor: controller plus datapath.
// Depends on wmf_pkg, wmf_ctrl and wmf_dp.
//
//   channel   handshake            payload         direction
//   request   start / busy         req_i (req_t)   in
//   result    done_o strobe        rsp_o (rsp_t)   out
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i  in
//
// Each word passes the accept, execute (ring memory write or read plus level
// update) and result steps, with the result on the ports; the registered ring
// memory read sets the execute/result split.
// A new word is accepted in the cycle after the result strobe.
// Reset clears pointers, level, counters and notices; the ring memory has no
// clearing pass and its entries are read only after being written.
// The result is shown for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module watermark_fifo_flood_monitor #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire wmf_pkg::req_t                  req_i,
  output logic                                done_o,
  output wmf_pkg::rsp_t                       rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wmf_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import wmf_pkg::*;

  ctrl_cmd_t cmd;

  // Sequencer
  wmf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Ring, monitor and result registers
  wmf_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

  assign done_o = cmd.resp;

endmodule

`default_nettype wire
